/* rtl/gkta_pkg.sv */
package gkta_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CoordW     = 12;
  localparam int unsigned SumW       = CoordW + 1;
  localparam int unsigned CellW      = CoordW + 1;
  localparam int unsigned ClsW       = 8;
  localparam int unsigned KeyW       = ClsW + 2 * CellW;
  localparam int unsigned PoseW      = 64;
  localparam int unsigned CsW        = 9;
  localparam int unsigned RadW       = 12;
  localparam int unsigned CfgDataW   = 12;
  localparam int unsigned CfgIdxW    = 1;

  // divider: (sum + cs) / (2 * cs)
  localparam int unsigned NumW  = SumW + 1;
  localparam int unsigned DenW  = CsW + 1;
  localparam int unsigned DivCntW = $clog2(NumW + 1);

  // scan datapath widths
  localparam int unsigned OrgW  = CellW + CsW;
  localparam int unsigned DiffW = OrgW + 3;
  localparam int unsigned SqW   = 2 * DiffW;
  localparam int unsigned DistW = SqW + 1;

  localparam logic [CfgIdxW-1:0] CfgCellSize   = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgMatchRadius = 1'd1;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusStale = 2'd1;
  localparam logic [1:0] StatusFail  = 2'd2;

endpackage

/* rtl/gkta_div.sv */
module gkta_div
  import gkta_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic [CellW-1:0] quot_o
);

  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0]    num_q, num_d;
  logic [DenW-1:0]    rem_q, rem_d;
  logic [DenW-1:0]    den_q, den_d;
  logic [DenW:0]      trial;
  logic               ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_q, num_q[NumW-1]};
    ge    = trial >= {1'b0, den_q};
    cnt_d = cnt_q;
    num_d = num_q;
    rem_d = rem_q;
    den_d = den_q;
    if (start_i) begin
      cnt_d = DivCntW'(NumW);
      num_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      num_d = {num_q[NumW-2:0], ge};
      rem_d = ge ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      num_q <= '0;
      rem_q <= '0;
      den_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      num_q <= num_d;
      rem_q <= rem_d;
      den_q <= den_d;
    end
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = num_q[CellW-1:0];

  dv_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DivCntW'(NumW)) else $error("divider count out of range");
  dv_rem_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (rem_q < den_q)) else $error("remainder not below divisor");
  dv_start_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_o) else $error("divider did not start");

endmodule

/* rtl/grid_keyed_track_association.sv */
// per detection: divider, scan start, a read of every table entry plus the scan
// pipeline drain, scan end, pose read, finish
// a new detection is taken only once the last one has finished; the scan of the key
// memory reads one entry per cycle; the result register frees the input side
// reset: async active low, track table cleared through per-entry valid flops,
// cell_size 16 and match_radius 32
module grid_keyed_track_association
  import gkta_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ClsW-1:0]     object_class_i,
  input  logic [CoordW-1:0]   box_left_i,
  input  logic [CoordW-1:0]   box_top_i,
  input  logic [CoordW-1:0]   box_right_i,
  input  logic [CoordW-1:0]   box_bottom_i,
  input  logic                pose_valid_i,
  input  logic [PoseW-1:0]    pose_in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [PoseW-1:0]    pose_out_o,
  output logic [IdxW-1:0]     track_slot_o,
  output logic                slot_valid_o,
  output logic                table_full_o
);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_SCAN, S_POSE, S_FIN} state_e;

  state_e state_q;

  logic [CsW-1:0]   cell_size_q;
  logic [RadW-1:0]  radius_q;
  logic [CsW-1:0]   cs_q;
  logic [ClsW-1:0]  cls_q;
  logic [SumW-1:0]  sx2_q, sy2_q;
  logic             fresh_q;
  logic [PoseW-1:0] pose_q;

  logic [TableDepth-1:0] ev_q;
  logic [KeyW-1:0]  key_mem [TableDepth];
  logic [PoseW-1:0] pose_mem [TableDepth];
  logic [KeyW-1:0]  key_rd_q;
  logic [PoseW-1:0] pose_rd_q;

  logic [IdxW:0]    issue_q;
  logic             p1_vld_q, p2_vld_q, p3_vld_q;
  logic [IdxW-1:0]  p1_idx_q, p2_idx_q, p3_idx_q;
  logic             p2_cls_q, p3_cls_q;
  logic [OrgW-1:0]  ox_q, oy_q;
  logic [SqW-1:0]   sqx_q, sqy_q;
  logic [DistW-1:0] best_q;
  logic             exact_q, near_q;
  logic [IdxW-1:0]  exact_idx_q, near_idx_q;

  logic             hit_q, free_q;
  logic [IdxW-1:0]  hit_idx_q, free_idx_q;

  logic             out_valid_q, slot_valid_q, full_q;
  logic [1:0]       status_q;
  logic [PoseW-1:0] pose_out_q;
  logic [IdxW-1:0]  slot_q;

  logic             accept, div_start, dx_busy, dy_busy;
  logic [CsW-1:0]   cs_in;
  logic [CellW-1:0] cx, cy;
  logic [KeyW-1:0]  key;
  logic             p1_exact, p1_cls;
  logic signed [DiffW-1:0] dx, dy;
  logic [DistW-1:0] dsq;
  logic             scan_done, hit, free_found;
  logic [IdxW-1:0]  hit_idx, free_idx;
  logic             fin_go, wr_en;
  logic [IdxW-1:0]  wr_idx;
  logic [RadW:0]    r2;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = state_q != S_IDLE;
  assign cs_in      = (cell_size_q == '0) ? CsW'(1) : cell_size_q;
  assign div_start  = accept;
  assign key        = {cls_q, cx, cy};
  assign r2         = {radius_q, 1'b0};

  gkta_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (NumW'(box_left_i) + NumW'(box_right_i) + NumW'(cs_in)),
    .den_i   ({cs_in, 1'b0}),
    .busy_o  (dx_busy),
    .quot_o  (cx)
  );

  gkta_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (NumW'(box_top_i) + NumW'(box_bottom_i) + NumW'(cs_in)),
    .den_i   ({cs_in, 1'b0}),
    .busy_o  (dy_busy),
    .quot_o  (cy)
  );

  // scan datapath: origin products, squared offsets, sum and compare
  always_comb begin
    p1_exact = ev_q[p1_idx_q] && (key_rd_q == key);
    p1_cls   = ev_q[p1_idx_q] && (key_rd_q[KeyW-1 -: ClsW] == cls_q);
    dx   = $signed(DiffW'(sx2_q)) - $signed({2'b00, ox_q, 1'b0});
    dy   = $signed(DiffW'(sy2_q)) - $signed({2'b00, oy_q, 1'b0});
    dsq  = DistW'(sqx_q) + DistW'(sqy_q);
    scan_done = issue_q[IdxW] && !p1_vld_q && !p2_vld_q && !p3_vld_q;
  end

  always_comb begin
    hit      = exact_q || near_q;
    hit_idx  = exact_q ? exact_idx_q : (near_q ? near_idx_q : '0);
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (!ev_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  assign fin_go = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);
  assign wr_en  = fin_go && fresh_q && (hit_q || free_q);
  assign wr_idx = hit_q ? hit_idx_q : free_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cell_size_q  <= CsW'(16);
      radius_q     <= RadW'(32);
      cs_q         <= '0;
      cls_q        <= '0;
      sx2_q        <= '0;
      sy2_q        <= '0;
      fresh_q      <= 1'b0;
      pose_q       <= '0;
      ev_q         <= '0;
      issue_q      <= '0;
      p1_vld_q     <= 1'b0;
      p2_vld_q     <= 1'b0;
      p3_vld_q     <= 1'b0;
      p1_idx_q     <= '0;
      p2_idx_q     <= '0;
      p3_idx_q     <= '0;
      p2_cls_q     <= 1'b0;
      p3_cls_q     <= 1'b0;
      ox_q         <= '0;
      oy_q         <= '0;
      sqx_q        <= '0;
      sqy_q        <= '0;
      best_q       <= '0;
      exact_q      <= 1'b0;
      near_q       <= 1'b0;
      exact_idx_q  <= '0;
      near_idx_q   <= '0;
      hit_q        <= 1'b0;
      free_q       <= 1'b0;
      hit_idx_q    <= '0;
      free_idx_q   <= '0;
      out_valid_q  <= 1'b0;
      status_q     <= StatusFail;
      pose_out_q   <= '0;
      slot_q       <= '0;
      slot_valid_q <= 1'b0;
      full_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgCellSize:    cell_size_q <= cfg_data_i[CsW-1:0];
          CfgMatchRadius: radius_q    <= cfg_data_i[RadW-1:0];
          default: ;
        endcase
      end

      // scan pipeline runs freely, fed only in the scan state
      p1_vld_q <= (state_q == S_SCAN) && !issue_q[IdxW];
      p1_idx_q <= issue_q[IdxW-1:0];
      p2_vld_q <= p1_vld_q;
      p2_idx_q <= p1_idx_q;
      p2_cls_q <= p1_cls;
      ox_q     <= OrgW'(key_rd_q[2*CellW-1:CellW]) * OrgW'(cs_q);
      oy_q     <= OrgW'(key_rd_q[CellW-1:0]) * OrgW'(cs_q);
      p3_vld_q <= p2_vld_q;
      p3_idx_q <= p2_idx_q;
      p3_cls_q <= p2_cls_q;
      sqx_q    <= SqW'(dx * dx);
      sqy_q    <= SqW'(dy * dy);

      if (p1_vld_q && p1_exact && !exact_q) begin
        exact_q     <= 1'b1;
        exact_idx_q <= p1_idx_q;
      end
      // later slot wins on equal distance
      if (p3_vld_q && p3_cls_q && (dsq <= best_q)) begin
        best_q     <= dsq;
        near_q     <= 1'b1;
        near_idx_q <= p3_idx_q;
      end

      if (!out_stall_i && !fin_go) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cs_q    <= cs_in;
            cls_q   <= object_class_i;
            sx2_q   <= SumW'(box_left_i) + SumW'(box_right_i);
            sy2_q   <= SumW'(box_top_i) + SumW'(box_bottom_i);
            fresh_q <= pose_valid_i;
            pose_q  <= pose_in_i;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (!dx_busy && !dy_busy) begin
            issue_q <= '0;
            exact_q <= 1'b0;
            near_q  <= 1'b0;
            best_q  <= DistW'(r2 * r2);
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!issue_q[IdxW]) issue_q <= issue_q + 1'b1;
          if (scan_done) state_q <= S_POSE;
        end
        S_POSE: begin
          hit_q      <= hit;
          hit_idx_q  <= hit_idx;
          free_q     <= free_found;
          free_idx_q <= free_idx;
          state_q    <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            out_valid_q <= 1'b1;
            if (fresh_q) begin
              status_q     <= StatusOk;
              pose_out_q   <= pose_q;
              slot_q       <= (hit_q || free_q) ? wr_idx : '0;
              slot_valid_q <= hit_q || free_q;
              full_q       <= !(hit_q || free_q);
            end else if (hit_q) begin
              status_q     <= StatusStale;
              pose_out_q   <= pose_rd_q;
              slot_q       <= hit_idx_q;
              slot_valid_q <= 1'b1;
              full_q       <= 1'b0;
            end else begin
              status_q     <= StatusFail;
              pose_out_q   <= '0;
              slot_q       <= '0;
              slot_valid_q <= 1'b0;
              full_q       <= 1'b0;
            end
            if (wr_en) ev_q[wr_idx] <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // track memories, one read and one write port each
  always_ff @(posedge clk_i) begin
    key_rd_q  <= key_mem[issue_q[IdxW-1:0]];
    pose_rd_q <= pose_mem[hit_idx];
    if (wr_en) begin
      key_mem[wr_idx]  <= key;
      pose_mem[wr_idx] <= pose_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign pose_out_o   = pose_out_q;
  assign track_slot_o = slot_q;
  assign slot_valid_o = slot_valid_q;
  assign table_full_o = full_q;

  gk_issue_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_q <= (IdxW+1)'(TableDepth)) else $error("scan index past table");
  gk_out_src_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN)) else $error("result without finish");
  gk_full_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(table_full_o && slot_valid_o)) else $error("full with valid slot");
  gk_scan_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_vld_q |-> (state_q == S_SCAN)) else $error("table read outside scan");

endmodule
